@@ src/cfp_pkg.sv @@
// Package for the control frame parser: transaction payload types,
// header offsets, magic bytes and status codes.
// No dependencies.
package cfp_pkg;

    // Input transaction: one message byte and its final-byte flag.
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       end_of_message;
    } cfp_in_t;

    // Result transaction: a payload byte or an end-of-frame report.
    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [1:0]  frame_status;
        logic [3:0]  message_type;
        logic [1:0]  data_kind;
        logic [1:0]  device_type;
        logic [15:0] source_id;
        logic [15:0] dest_id;
        logic [15:0] payload_length;
    } cfp_out_t;

    // Result kinds.
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_REPORT  = 1'b1;

    // Frame status codes.
    localparam logic [1:0] STATUS_OK           = 2'd0;
    localparam logic [1:0] STATUS_HEADER_ERR   = 2'd1;
    localparam logic [1:0] STATUS_LENGTH_ERR   = 2'd2;
    localparam logic [1:0] STATUS_CHECKSUM_ERR = 2'd3;

    // Magic bytes.
    localparam logic [7:0] MAGIC_D = 8'h44;
    localparam logic [7:0] MAGIC_S = 8'h53;

    // Header byte offsets.
    localparam logic [15:0] POS_MAGIC0   = 16'd0;
    localparam logic [15:0] POS_MAGIC1   = 16'd1;
    localparam logic [15:0] POS_MAGIC2   = 16'd2;
    localparam logic [15:0] POS_MAGIC3   = 16'd3;
    localparam logic [15:0] POS_TYPE     = 16'd4;
    localparam logic [15:0] POS_LEN_HI   = 16'd5;
    localparam logic [15:0] POS_LEN_LO   = 16'd6;
    localparam logic [15:0] POS_SRC_HI   = 16'd7;
    localparam logic [15:0] POS_SRC_LO   = 16'd8;
    localparam logic [15:0] POS_DST_HI   = 16'd9;
    localparam logic [15:0] POS_DST_LO   = 16'd10;
    localparam logic [15:0] POS_PAYLOAD  = 16'd15;

    // Length limits.
    localparam logic [15:0] MIN_FRAME_LEN = 16'd16;
    localparam logic [15:0] COUNT_MAX     = 16'hffff;

endpackage

@@ src/cfp_parse.sv @@
// Frame parser core: header capture, byte count, checksum and status.
// Depends on cfp_pkg.
module cfp_parse (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            accept,
    input  cfp_pkg::cfp_in_t  in_data,
    output logic            res_valid,
    output cfp_pkg::cfp_out_t res_data
);
    import cfp_pkg::*;

    logic [15:0] byte_count_reg, byte_count_next;
    logic [7:0]  running_sum_reg, running_sum_next;
    logic        header_bad_reg, header_bad_next;
    logic [7:0]  type_byte_reg, type_byte_next;
    logic [15:0] declared_length_reg, declared_length_next;
    logic [15:0] src_hold_reg, src_hold_next;
    logic [15:0] dst_hold_reg, dst_hold_next;
    logic        overflowed_reg, overflowed_next;

    // Header fields as they stand after this byte.
    logic        hdr_bad;
    logic [7:0]  hdr_type;
    logic [15:0] hdr_len;
    logic [15:0] hdr_src;
    logic [15:0] hdr_dst;
    logic        len_bad;
    logic [7:0]  b;
    logic        last;

    assign b    = in_data.rx_byte;
    assign last = in_data.end_of_message;

    // Capture of the header byte at the current offset.
    always_comb begin
        hdr_bad  = header_bad_reg;
        hdr_type = type_byte_reg;
        hdr_len  = declared_length_reg;
        hdr_src  = src_hold_reg;
        hdr_dst  = dst_hold_reg;
        case (byte_count_reg)
            POS_MAGIC0, POS_MAGIC2: begin
                if (b != MAGIC_D) hdr_bad = 1'b1;
            end
            POS_MAGIC1, POS_MAGIC3: begin
                if (b != MAGIC_S) hdr_bad = 1'b1;
            end
            POS_TYPE:   hdr_type = b;
            POS_LEN_HI: hdr_len  = {b, declared_length_reg[7:0]};
            POS_LEN_LO: hdr_len  = {declared_length_reg[15:8], b};
            POS_SRC_HI: hdr_src  = {b, src_hold_reg[7:0]};
            POS_SRC_LO: hdr_src  = {src_hold_reg[15:8], b};
            POS_DST_HI: hdr_dst  = {b, dst_hold_reg[7:0]};
            POS_DST_LO: hdr_dst  = {dst_hold_reg[15:8], b};
            default: begin
            end
        endcase
    end

    // The received count includes the final byte; a full counter means overflow.
    assign len_bad = overflowed_reg || (byte_count_reg == COUNT_MAX) ||
                     (byte_count_reg < POS_PAYLOAD) ||
                     ((byte_count_reg + 16'd1) != hdr_len);

    // Result of this byte.
    always_comb begin
        res_data  = '0;
        res_valid = 1'b0;
        if (last) begin
            res_valid               = 1'b1;
            res_data.kind           = KIND_REPORT;
            res_data.message_type   = hdr_type[7:4];
            res_data.data_kind      = hdr_type[3:2];
            res_data.device_type    = hdr_type[1:0];
            res_data.source_id      = hdr_src;
            res_data.dest_id        = hdr_dst;
            res_data.payload_length = (hdr_len >= MIN_FRAME_LEN) ?
                                      (hdr_len - MIN_FRAME_LEN) : 16'd0;
            if (hdr_bad) begin
                res_data.frame_status = STATUS_HEADER_ERR;
            end else if (len_bad) begin
                res_data.frame_status = STATUS_LENGTH_ERR;
            end else if (running_sum_reg != b) begin
                res_data.frame_status = STATUS_CHECKSUM_ERR;
            end else begin
                res_data.frame_status = STATUS_OK;
            end
        end else if (byte_count_reg >= POS_PAYLOAD) begin
            res_valid             = 1'b1;
            res_data.kind         = KIND_PAYLOAD;
            res_data.payload_byte = b;
        end
    end

    // Next state: advance within a message, clear after the final byte.
    always_comb begin
        byte_count_next      = byte_count_reg;
        running_sum_next     = running_sum_reg;
        header_bad_next      = header_bad_reg;
        type_byte_next       = type_byte_reg;
        declared_length_next = declared_length_reg;
        src_hold_next        = src_hold_reg;
        dst_hold_next        = dst_hold_reg;
        overflowed_next      = overflowed_reg;
        if (accept) begin
            if (last) begin
                byte_count_next      = '0;
                running_sum_next     = '0;
                header_bad_next      = 1'b0;
                type_byte_next       = '0;
                declared_length_next = '0;
                src_hold_next        = '0;
                dst_hold_next        = '0;
                overflowed_next      = 1'b0;
            end else begin
                running_sum_next     = running_sum_reg + b;
                header_bad_next      = hdr_bad;
                type_byte_next       = hdr_type;
                declared_length_next = hdr_len;
                src_hold_next        = hdr_src;
                dst_hold_next        = hdr_dst;
                if (byte_count_reg == COUNT_MAX) begin
                    overflowed_next = 1'b1;
                end else begin
                    byte_count_next = byte_count_reg + 16'd1;
                end
            end
        end
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg      <= '0;
            running_sum_reg     <= '0;
            header_bad_reg      <= 1'b0;
            type_byte_reg       <= '0;
            declared_length_reg <= '0;
            src_hold_reg        <= '0;
            dst_hold_reg        <= '0;
            overflowed_reg      <= 1'b0;
        end else begin
            byte_count_reg      <= byte_count_next;
            running_sum_reg     <= running_sum_next;
            header_bad_reg      <= header_bad_next;
            type_byte_reg       <= type_byte_next;
            declared_length_reg <= declared_length_next;
            src_hold_reg        <= src_hold_next;
            dst_hold_reg        <= dst_hold_next;
            overflowed_reg      <= overflowed_next;
        end
    end

endmodule

@@ src/cfp_out_buf.sv @@
// Two-entry result buffer (output register plus skid register).
// Depends on cfp_pkg.
module cfp_out_buf (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  cfp_pkg::cfp_out_t push_data,
    output logic              has_space,
    output logic              m_valid,
    input  logic              m_ready,
    output cfp_pkg::cfp_out_t m_data
);
    import cfp_pkg::*;

    cfp_out_t    head_reg, head_next;
    cfp_out_t    skid_reg, skid_next;
    logic [1:0]  count_reg, count_next;
    logic        pop;

    assign m_valid   = (count_reg != 2'd0);
    assign m_data    = head_reg;
    assign has_space = (count_reg != 2'd2);
    assign pop       = m_valid && m_ready;

    // Entry movement for push and pop.
    always_comb begin
        head_next  = head_reg;
        skid_next  = skid_reg;
        count_next = count_reg;
        case (count_reg)
            2'd0: begin
                if (push) begin
                    head_next  = push_data;
                    count_next = 2'd1;
                end
            end
            2'd1: begin
                if (push && pop) begin
                    head_next = push_data;
                end else if (push) begin
                    skid_next  = push_data;
                    count_next = 2'd2;
                end else if (pop) begin
                    count_next = 2'd0;
                end
            end
            2'd2: begin
                if (pop) begin
                    head_next  = skid_reg;
                    count_next = 2'd1;
                end
            end
            default: begin
                count_next = 2'd0;
            end
        endcase
    end

    // Fill count is control state; entries hold payload only.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

endmodule

@@ src/control_frame_parser.sv @@
// Control frame parser top level.
// Depends on cfp_pkg, cfp_parse and cfp_out_buf.
//
// Usage:
// The s_ channel takes one message byte per transaction, with end_of_message
// set on the final (checksum) byte. The m_ channel returns a payload-byte
// transaction for every non-final byte at offset 15 or later, and one status
// report transaction on the final byte. Header bytes produce no result.
// The result of an accepted byte is registered in the result buffer and is
// offered on m_valid right after that edge unless an earlier result stays unread.
// The parser takes one byte per cycle while s_ready is high; the parse logic
// between the state registers and the result buffer is combinational.
// A two-entry result buffer lets s_ready stay high while one result waits;
// s_ready drops only when both entries are full, so a receiver stall backs
// up the input after two results, and nothing is lost.
// Synchronous active-low reset clears the parser to the start of a message
// and empties the result buffer. After the final byte the parser returns to
// the start-of-message state on its own.
module control_frame_parser (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  cfp_pkg::cfp_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output cfp_pkg::cfp_out_t m_data
);
    import cfp_pkg::*;

    logic     accept;
    logic     res_valid;
    cfp_out_t res_data;
    logic     has_space;

    // An input transaction completes when the result buffer has a free entry.
    assign s_ready = has_space;
    assign accept  = s_valid && s_ready;

    cfp_parse u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .in_data   (s_data),
        .res_valid (res_valid),
        .res_data  (res_data)
    );

    cfp_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (accept && res_valid),
        .push_data (res_data),
        .has_space (has_space),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

@@ sim/control_frame_parser_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for control_frame_parser: byte-level frame stimulus,
// a transaction-level parser prediction and an in-order result checker.
// Depends on cfp_pkg and the control_frame_parser RTL.
module control_frame_parser_tb;
    import cfp_pkg::*;

    localparam int    CLK_PERIOD  = 12;
    localparam longint TIMEOUT_NS = 64'd24_000_000;
    localparam int    DRAIN_LIMIT = 20000;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    cfp_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    cfp_out_t m_data;

    // Results the parser should still produce, oldest first.
    cfp_out_t frame_results_q[$];

    // Parser state as the prediction sees it.
    logic [15:0] byte_cnt;
    logic [7:0]  csum_acc;
    logic        magic_bad;
    logic [7:0]  type_reg;
    logic [15:0] decl_len;
    logic [15:0] src_reg;
    logic [15:0] dst_reg;
    logic        cnt_ovf;

    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    int error_count     = 0;
    int bytes_sent      = 0;
    int payloads_seen   = 0;
    int reports_seen    = 0;
    int status_seen[4]  = '{0, 0, 0, 0};

    control_frame_parser u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Receiver back-pressure.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic flag_error(input string msg);
        error_count++;
        $display("tb: mismatch at %0t: %s", $realtime, msg);
    endtask

    task automatic clear_parser_state();
        byte_cnt  = '0;
        csum_acc  = '0;
        magic_bad = 1'b0;
        type_reg  = '0;
        decl_len  = '0;
        src_reg   = '0;
        dst_reg   = '0;
        cnt_ovf   = 1'b0;
    endtask

    // Advance the parser state by one accepted byte and queue what it yields.
    task automatic parse_byte(input cfp_in_t item);
        cfp_out_t res;
        logic     len_bad;
        res = '0;
        if (byte_cnt < POS_PAYLOAD) begin
            case (byte_cnt)
                POS_MAGIC0, POS_MAGIC2: if (item.rx_byte != MAGIC_D) magic_bad = 1'b1;
                POS_MAGIC1, POS_MAGIC3: if (item.rx_byte != MAGIC_S) magic_bad = 1'b1;
                POS_TYPE:   type_reg       = item.rx_byte;
                POS_LEN_HI: decl_len[15:8] = item.rx_byte;
                POS_LEN_LO: decl_len[7:0]  = item.rx_byte;
                POS_SRC_HI: src_reg[15:8]  = item.rx_byte;
                POS_SRC_LO: src_reg[7:0]   = item.rx_byte;
                POS_DST_HI: dst_reg[15:8]  = item.rx_byte;
                POS_DST_LO: dst_reg[7:0]   = item.rx_byte;
                default: ;
            endcase
        end
        if (!item.end_of_message) begin
            if (byte_cnt >= POS_PAYLOAD) begin
                res.kind         = KIND_PAYLOAD;
                res.payload_byte = item.rx_byte;
                frame_results_q.push_back(res);
            end
            csum_acc = csum_acc + item.rx_byte;
            if (byte_cnt == COUNT_MAX) begin
                cnt_ovf = 1'b1;
            end else begin
                byte_cnt = byte_cnt + 16'd1;
            end
        end else begin
            // A count already at its maximum means more than 65535 bytes arrived.
            len_bad = cnt_ovf || (byte_cnt == COUNT_MAX) ||
                      (byte_cnt + 16'd1 < MIN_FRAME_LEN) || (byte_cnt + 16'd1 != decl_len);
            res.kind = KIND_REPORT;
            if (magic_bad) begin
                res.frame_status = STATUS_HEADER_ERR;
            end else if (len_bad) begin
                res.frame_status = STATUS_LENGTH_ERR;
            end else if (csum_acc != item.rx_byte) begin
                res.frame_status = STATUS_CHECKSUM_ERR;
            end else begin
                res.frame_status = STATUS_OK;
            end
            res.message_type   = type_reg[7:4];
            res.data_kind      = type_reg[3:2];
            res.device_type    = type_reg[1:0];
            res.source_id      = src_reg;
            res.dest_id        = dst_reg;
            res.payload_length = (decl_len >= MIN_FRAME_LEN) ? decl_len - MIN_FRAME_LEN : 16'd0;
            frame_results_q.push_back(res);
            clear_parser_state();
        end
    endtask

    task automatic compare_field(input string name, input logic [15:0] got,
                                 input logic [15:0] want);
        if (got !== want) begin
            flag_error($sformatf("%s got %0h expected %0h", name, got, want));
        end
    endtask

    task automatic check_result(input cfp_out_t got);
        cfp_out_t want;
        if (frame_results_q.size() == 0) begin
            flag_error("result transaction with nothing expected");
            return;
        end
        want = frame_results_q.pop_front();
        compare_field("kind", got.kind, want.kind);
        compare_field("payload_byte", got.payload_byte, want.payload_byte);
        compare_field("frame_status", got.frame_status, want.frame_status);
        compare_field("message_type", got.message_type, want.message_type);
        compare_field("data_kind", got.data_kind, want.data_kind);
        compare_field("device_type", got.device_type, want.device_type);
        compare_field("source_id", got.source_id, want.source_id);
        compare_field("dest_id", got.dest_id, want.dest_id);
        compare_field("payload_length", got.payload_length, want.payload_length);
        if (want.kind == KIND_REPORT) begin
            reports_seen++;
            status_seen[want.frame_status]++;
        end else begin
            payloads_seen++;
        end
    endtask

    // Result channel monitor.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            check_result(m_data);
        end
    end

    // Offer one byte, wait for its transaction, then update the prediction.
    task automatic send_byte(input cfp_in_t item);
        int gap;
        gap = 0;
        while ($urandom_range(99) < sender_idle_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
        parse_byte(item);
    endtask

    task automatic send_frame(input logic [7:0] frame[$]);
        cfp_in_t item;
        foreach (frame[i]) begin
            item.rx_byte        = frame[i];
            item.end_of_message = (i == frame.size() - 1);
            send_byte(item);
        end
    endtask

    // Hold off the sender until every predicted result has been seen or the wait limit runs out.
    task automatic drain_results();
        int waited;
        s_valid <= 1'b0;
        waited = 0;
        while (frame_results_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (4) @(posedge aclk);
    endtask

    // Recompute the trailing checksum byte over everything before it.
    task automatic reseal(ref logic [7:0] frame[$]);
        logic [7:0] sum;
        sum = '0;
        for (int i = 0; i < frame.size() - 1; i++) sum = sum + frame[i];
        frame[frame.size() - 1] = sum;
    endtask

    // Well-formed frame with a matching declared length and checksum.
    task automatic build_frame(input logic [7:0] type_b, input logic [15:0] src,
                               input logic [15:0] dst, input int payload_n,
                               output logic [7:0] frame[$]);
        logic [15:0] total;
        total = 16'(payload_n + 16);
        frame = {MAGIC_D, MAGIC_S, MAGIC_D, MAGIC_S, type_b, total[15:8], total[7:0],
                 src[15:8], src[7:0], dst[15:8], dst[7:0]};
        repeat (4) frame.push_back(8'($urandom));
        repeat (payload_n) frame.push_back(8'($urandom));
        frame.push_back(8'h00);
        reseal(frame);
    endtask

    task automatic set_declared_length(ref logic [7:0] frame[$], input logic [15:0] len);
        frame[POS_LEN_HI] = len[15:8];
        frame[POS_LEN_LO] = len[7:0];
    endtask

    task automatic test_well_formed_frames();
        logic [7:0] frame[$];
        // Shortest legal frame, no payload.
        build_frame(8'h00, 16'h0000, 16'h0000, 0, frame);
        send_frame(frame);
        // All-ones header fields and extreme payload values.
        build_frame(8'hff, 16'hffff, 16'hffff, 3, frame);
        frame[POS_PAYLOAD]     = 8'h00;
        frame[POS_PAYLOAD + 1] = 8'hff;
        frame[POS_PAYLOAD + 2] = 8'h5a;
        reseal(frame);
        send_frame(frame);
        build_frame(8'ha6, 16'h1234, 16'hfedc, 1, frame);
        send_frame(frame);
        drain_results();
    endtask

    task automatic test_magic_errors();
        logic [7:0] frame[$];
        // Each magic byte wrong in an otherwise valid frame.
        for (int pos = 0; pos < 4; pos++) begin
            build_frame(8'h3c, 16'h0102, 16'h0304, 1, frame);
            frame[pos] = frame[pos] ^ 8'h20;
            reseal(frame);
            send_frame(frame);
        end
        // Header error wins over a short message.
        frame = {MAGIC_D, 8'h00, MAGIC_D};
        send_frame(frame);
        // Header error wins over a bad checksum.
        build_frame(8'h81, 16'h5555, 16'haaaa, 2, frame);
        frame[POS_MAGIC3] = 8'h00;
        frame[frame.size() - 1] = ~frame[frame.size() - 1];
        send_frame(frame);
        // A lone final byte that is not the first magic byte.
        frame = {8'hff};
        send_frame(frame);
        drain_results();
    endtask

    task automatic test_length_errors();
        logic [7:0] frame[$];
        // Declared length one too many and one too few.
        build_frame(8'h12, 16'h0a0b, 16'h0c0d, 4, frame);
        set_declared_length(frame, 16'd21);
        reseal(frame);
        send_frame(frame);
        build_frame(8'h12, 16'h0a0b, 16'h0c0d, 4, frame);
        set_declared_length(frame, 16'd19);
        reseal(frame);
        send_frame(frame);
        // Declared length below the minimum reports a zero payload length.
        build_frame(8'h47, 16'h00ff, 16'hff00, 0, frame);
        set_declared_length(frame, 16'd15);
        reseal(frame);
        send_frame(frame);
        // Fifteen bytes that declare fifteen are still too short.
        build_frame(8'h47, 16'h00ff, 16'hff00, 0, frame);
        void'(frame.pop_back());
        set_declared_length(frame, 16'd15);
        reseal(frame);
        send_frame(frame);
        // Message ends in the middle of the header with good magic.
        build_frame(8'hc9, 16'hbeef, 16'h7777, 0, frame);
        frame = frame[0:9];
        send_frame(frame);
        // A lone final byte that matches the first magic byte.
        frame = {MAGIC_D};
        send_frame(frame);
        drain_results();
    endtask

    task automatic test_checksum_errors();
        logic [7:0] frame[$];
        build_frame(8'h6e, 16'h4321, 16'h8765, 5, frame);
        frame[frame.size() - 1] = frame[frame.size() - 1] + 8'd1;
        send_frame(frame);
        build_frame(8'h00, 16'hffff, 16'h0000, 0, frame);
        frame[frame.size() - 1] = frame[frame.size() - 1] ^ 8'h80;
        send_frame(frame);
        drain_results();
    endtask

    // Mostly well-formed frames with random content, plus broken ones and noise.
    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int n_bytes);
        logic [7:0]  frame[$];
        logic [15:0] len;
        int          start;
        int          pick;
        int          idx;
        sender_idle_pct = idle_pct;
        recv_stall_pct  = stall_pct;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes) begin
            pick = $urandom_range(99);
            build_frame(8'($urandom), 16'($urandom), 16'($urandom),
                        ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(10),
                        frame);
            if (pick < 60) begin
                // Left well-formed.
            end else if (pick < 67) begin
                frame[frame.size() - 1] = frame[frame.size() - 1] ^ (8'h01 << $urandom_range(7));
            end else if (pick < 74) begin
                len = {frame[POS_LEN_HI], frame[POS_LEN_LO]};
                case ($urandom_range(2))
                    0: len = len + 16'd1;
                    1: len = len - 16'd1;
                    default: len = 16'($urandom);
                endcase
                set_declared_length(frame, len);
                reseal(frame);
            end else if (pick < 80) begin
                idx = $urandom_range(3);
                frame[idx] = frame[idx] ^ (8'h01 << $urandom_range(7));
                if ($urandom_range(1)) reseal(frame);
            end else if (pick < 88) begin
                frame = frame[0:$urandom_range(14)];
            end else begin
                frame.delete();
                repeat ($urandom_range(1, 24)) frame.push_back(8'($urandom));
            end
            send_frame(frame);
            if ($urandom_range(15) == 0) drain_results();
        end
        drain_results();
    endtask

    initial begin
        clear_parser_state();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_well_formed_frames();
        test_magic_errors();
        test_length_errors();
        test_checksum_errors();
        test_random_traffic(0, 0, 70);
        test_random_traffic(60, 0, 70);
        test_random_traffic(0, 60, 70);
        test_random_traffic(6, 6, 70);

        drain_results();
        if (frame_results_q.size() != 0) begin
            flag_error($sformatf("%0d expected results never arrived", frame_results_q.size()));
        end
        $display("tb: %0d bytes sent; %0d payload bytes and %0d frame reports checked",
                 bytes_sent, payloads_seen, reports_seen);
        $display("tb: reports ok %0d, header %0d, length %0d, checksum %0d; %0d mismatches",
                 status_seen[STATUS_OK], status_seen[STATUS_HEADER_ERR],
                 status_seen[STATUS_LENGTH_ERR], status_seen[STATUS_CHECKSUM_ERR], error_count);
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #(TIMEOUT_NS);
        $display("tb: failure");
        $finish;
    end

endmodule

@@ control_frame_parser.f @@
src/cfp_pkg.sv
src/cfp_parse.sv
src/cfp_out_buf.sv
src/control_frame_parser.sv
sim/control_frame_parser_tb.sv
